>>> hw/rtl/tfi_pkg.sv
// Package for the thermodilution flow integrator: types, widths and constants.
package tfi_pkg;

    // Boxcar filter geometry.
    localparam int WINDOW     = 32;
    localparam int IDX_W      = $clog2(WINDOW);
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = SAMPLE_W + IDX_W;
    localparam int FILT_SHIFT = 5;

    // Accumulator, area and flow widths.
    localparam int ACC_W        = 48;
    localparam int AREA_W       = 40;
    localparam int FLOW_W       = 35;
    localparam int NUM_W        = 33;
    localparam int AREA_DIVISOR = 400;

    // Serial divider widths.
    localparam int DIV_W = 48;
    localparam int CNT_W = $clog2(DIV_W + 1);

    // Area division by the constant divisor: one quotient digit a cycle found by
    // reciprocal multiplication, with the remainder carried to the next digit.
    localparam int     AREA_DIGIT_W  = 8;
    localparam int     AREA_STEPS    = ACC_W / AREA_DIGIT_W;
    localparam int     AREA_REM_W    = $clog2(AREA_DIVISOR);
    localparam int     AREA_T_W      = AREA_REM_W + AREA_DIGIT_W;
    localparam int     AREA_RECIP_SH = AREA_T_W + AREA_REM_W;
    localparam int     AREA_RECIP_W  = AREA_T_W + 1;
    localparam longint AREA_RECIP    =
        ((longint'(1) <<< AREA_RECIP_SH) + AREA_DIVISOR - 1) / AREA_DIVISOR;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ITEMP  = 1'b1;

    localparam int OP_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_FILTER   = 2'd0,
        OP_BASELINE = 2'd1,
        OP_ACCUM    = 2'd2,
        OP_FINISH   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FILT,
        ST_APPLY,
        ST_DIV_AREA,
        ST_AREA,
        ST_FLOW_START,
        ST_DIV_FLOW,
        ST_FLOW,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic mem_rd;
        logic filt_upd;
        logic apply;
        logic div_start_area;
        logic div_start_flow;
        logic area_step;
        logic div_step;
        logic area_set;
        logic mul;
        logic flow_set;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic div_done;
        logic area_zero;
    } t_sts;

endpackage

>>> hw/rtl/tfi_ctrl.sv
// Controller state machine of the thermodilution flow integrator.
module tfi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  tfi_pkg::t_sts  i_sts,
    output tfi_pkg::t_cmd  o_cmd
);
    import tfi_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    // The output register can take a new word when empty or being drained.
    assign w_out_free = !r_out_valid || !i_out_stall;

    // State register and output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (i_sts.op == OP_FINISH) n_state = ST_DIV_AREA;
                else                       n_state = ST_FILT;
            end
            ST_FILT:       n_state = ST_APPLY;
            ST_APPLY:      n_state = ST_DONE;
            ST_DIV_AREA: begin
                if (i_sts.div_done) n_state = ST_AREA;
            end
            ST_AREA:       n_state = ST_FLOW_START;
            ST_FLOW_START: begin
                if (i_sts.area_zero) n_state = ST_DONE;
                else                 n_state = ST_DIV_FLOW;
            end
            ST_DIV_FLOW: begin
                if (i_sts.div_done) n_state = ST_FLOW;
            end
            ST_FLOW:       n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default:       n_state = ST_IDLE;
        endcase
    end

    // Commands for the datapath.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE:       o_cmd.accept = i_in_valid;
            ST_DECODE: begin
                if (i_sts.op == OP_FINISH) o_cmd.div_start_area = 1'b1;
                else                       o_cmd.mem_rd = 1'b1;
            end
            ST_FILT:       o_cmd.filt_upd = 1'b1;
            ST_APPLY:      o_cmd.apply = 1'b1;
            ST_DIV_AREA:   o_cmd.area_step = 1'b1;
            ST_AREA: begin
                o_cmd.area_set = 1'b1;
                o_cmd.mul      = 1'b1;
            end
            ST_FLOW_START: o_cmd.div_start_flow = !i_sts.area_zero;
            ST_DIV_FLOW:   o_cmd.div_step = 1'b1;
            ST_FLOW:       o_cmd.flow_set = 1'b1;
            ST_DONE:       o_cmd.out_load = w_out_free;
            default:       o_cmd = '0;
        endcase
    end

    // Output valid: set on load, cleared when the word is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load)                  n_out_valid = 1'b1;
        else if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> hw/rtl/tfi_dp.sv
// Datapath of the thermodilution flow integrator: filter, accumulator, divider.
module tfi_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  tfi_pkg::t_cmd                         i_cmd,
    output tfi_pkg::t_sts                         o_sts,
    input  logic                                  i_cfg_we,
    input  logic [tfi_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [tfi_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic [tfi_pkg::OP_W-1:0]              i_op,
    input  logic signed [tfi_pkg::SAMPLE_W-1:0]   i_temp_sample,
    output logic signed [tfi_pkg::SAMPLE_W-1:0]   o_filtered_temp,
    output logic signed [tfi_pkg::AREA_W-1:0]     o_area,
    output logic signed [tfi_pkg::FLOW_W-1:0]     o_flow,
    output logic                                  o_accum_saturated
);
    import tfi_pkg::*;

    localparam logic signed [DIV_W:0] AREA_MAX_X =
        {{(DIV_W-AREA_W+2){1'b0}}, {(AREA_W-1){1'b1}}};
    localparam logic signed [DIV_W:0] AREA_MIN_X =
        {{(DIV_W-AREA_W+2){1'b1}}, {(AREA_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ACC_MAX_V = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN_V = {1'b1, {(ACC_W-1){1'b0}}};

    // Configuration registers.
    logic        [CFG_DATA_W-1:0] r_vol;
    logic signed [SAMPLE_W-1:0]   r_itemp;

    // Item registers.
    t_op                        r_op;
    logic signed [SAMPLE_W-1:0] r_sample;

    // Filter state.
    logic signed [SAMPLE_W-1:0] r_win [WINDOW];
    logic        [WINDOW-1:0]   r_wvalid;
    logic        [IDX_W-1:0]    r_idx;
    logic signed [SAMPLE_W-1:0] r_old;
    logic                       r_old_vld;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SAMPLE_W-1:0] r_last_filt;

    // Measurement state.
    logic signed [SAMPLE_W-1:0] r_base;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_sat;
    logic signed [AREA_W-1:0]   r_area;
    logic signed [NUM_W-1:0]    r_num;
    logic signed [FLOW_W-1:0]   r_flow;

    // Divider state.
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;

    // Output word.
    logic signed [SAMPLE_W-1:0] r_o_filt;
    logic signed [AREA_W-1:0]   r_o_area;
    logic signed [FLOW_W-1:0]   r_o_flow;
    logic                       r_o_sat;

    logic signed [SAMPLE_W-1:0] w_old;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [SUM_W-1:0]    w_sh;
    logic signed [SAMPLE_W:0]   w_diff;
    logic signed [ACC_W:0]      w_acc_sum;
    logic                       w_acc_ovf;
    logic signed [ACC_W-1:0]    w_acc_next;
    logic [ACC_W-1:0]           w_acc_mag;
    logic [DIV_W:0]             w_shift;
    logic [DIV_W:0]             w_sub;
    logic                       w_ge;
    logic [AREA_T_W-1:0]              w_at;
    logic [AREA_T_W+AREA_RECIP_W-1:0] w_aprod;
    logic [AREA_DIGIT_W-1:0]          w_aq;
    logic [AREA_T_W-1:0]              w_arem;
    logic signed [DIV_W:0]      w_area_full;
    logic signed [AREA_W-1:0]   w_area_clamp;
    logic signed [SAMPLE_W:0]   w_tdiff;
    logic signed [2*SAMPLE_W+1:0] w_prod;
    logic [NUM_W-1:0]           w_num_mag;
    logic [AREA_W-1:0]          w_area_mag;
    logic [FLOW_W-1:0]          w_fq;
    logic                       w_flow_neg;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol   <= '0;
            r_itemp <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_VOLUME: r_vol   <= i_cfg_data;
                REG_ITEMP:  r_itemp <= $signed(i_cfg_data);
                default:    r_vol   <= r_vol;
            endcase
        end
    end

    // Item capture; flow reads zero unless a finish computes it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= t_op'(i_op);
            r_sample <= i_temp_sample;
        end
    end

    // Ring index steps down once per sample and wraps to the top.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= IDX_W'(WINDOW - 1);
        end else if (i_cmd.accept && t_op'(i_op) != OP_FINISH) begin
            if (r_idx == '0 || r_idx > IDX_W'(WINDOW - 1)) r_idx <= IDX_W'(WINDOW - 1);
            else                                         r_idx <= r_idx - 1'b1;
        end
    end

    // Window memory: registered read of the sample leaving the window, then write.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd)   r_old <= r_win[r_idx];
        if (i_cmd.filt_upd) r_win[r_idx] <= r_sample;
    end

    // Entry valid bits stand in for the cleared window after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid  <= '0;
            r_old_vld <= 1'b0;
        end else begin
            if (i_cmd.mem_rd)   r_old_vld <= r_wvalid[r_idx];
            if (i_cmd.filt_upd) r_wvalid[r_idx] <= 1'b1;
        end
    end

    // Running sum and filter output.
    assign w_old = r_old_vld ? r_old : '0;
    assign n_sum = r_sum + SUM_W'(r_sample) - SUM_W'(w_old);
    assign w_sh  = n_sum >>> FILT_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_last_filt <= '0;
        end else if (i_cmd.filt_upd) begin
            r_sum       <= n_sum;
            r_last_filt <= w_sh[SAMPLE_W-1:0];
        end
    end

    // Saturating accumulation of the temperature deficit.
    assign w_diff     = {r_base[SAMPLE_W-1], r_base} - {r_last_filt[SAMPLE_W-1], r_last_filt};
    assign w_acc_sum  = {r_acc[ACC_W-1], r_acc} + (ACC_W+1)'(w_diff);
    assign w_acc_ovf  = w_acc_sum[ACC_W] ^ w_acc_sum[ACC_W-1];
    assign w_acc_next = !w_acc_ovf ? w_acc_sum[ACC_W-1:0]
                      : (w_acc_sum[ACC_W] ? ACC_MIN_V : ACC_MAX_V);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_acc  <= '0;
            r_sat  <= 1'b0;
        end else if (i_cmd.apply) begin
            if (r_op == OP_BASELINE) begin
                r_base <= r_last_filt;
                r_acc  <= '0;
                r_sat  <= 1'b0;
            end else if (r_op == OP_ACCUM) begin
                r_acc <= w_acc_next;
                if (w_acc_ovf) r_sat <= 1'b1;
            end
        end
    end

    // Magnitudes feeding the divider.
    assign w_acc_mag  = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign w_num_mag  = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
    assign w_area_mag = r_area[AREA_W-1] ? AREA_W'(-r_area) : AREA_W'(r_area);

    // Restoring divider step: one quotient bit a cycle.
    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_sub   = w_shift - {1'b0, r_dvs};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    // Area digit step: the carried remainder and the next dividend byte give one
    // quotient byte through the reciprocal, and the new remainder by back-multiply.
    assign w_at    = {r_rem[AREA_REM_W-1:0], r_quo[DIV_W-1 -: AREA_DIGIT_W]};
    assign w_aprod = w_at * AREA_RECIP_W'(AREA_RECIP);
    assign w_aq    = w_aprod[AREA_RECIP_SH +: AREA_DIGIT_W];
    assign w_arem  = w_at - AREA_T_W'(w_aq) * AREA_T_W'(AREA_DIVISOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start_area) begin
            r_rem <= '0;
            r_quo <= w_acc_mag;
            r_cnt <= CNT_W'(AREA_STEPS);
        end else if (i_cmd.div_start_flow) begin
            r_rem <= '0;
            r_quo <= {w_num_mag, {(DIV_W-NUM_W){1'b0}}};
            r_dvs <= DIV_W'(w_area_mag);
            r_cnt <= CNT_W'(NUM_W);
        end else if (i_cmd.area_step && r_cnt != '0) begin
            r_rem <= DIV_W'(w_arem[AREA_REM_W-1:0]);
            r_quo <= {r_quo[DIV_W-AREA_DIGIT_W-1:0], w_aq};
            r_cnt <= r_cnt - 1'b1;
        end else if (i_cmd.div_step && r_cnt != '0) begin
            r_rem <= w_ge ? w_sub[DIV_W-1:0] : w_shift[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Signed area with clamping to its register width.
    assign w_area_full  = r_acc[ACC_W-1] ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign w_area_clamp = (w_area_full > AREA_MAX_X) ? AREA_MAX_X[AREA_W-1:0]
                        : (w_area_full < AREA_MIN_X) ? AREA_MIN_X[AREA_W-1:0]
                        : w_area_full[AREA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)            r_area <= '0;
        else if (i_cmd.area_set) r_area <= w_area_clamp;
    end

    // Flow numerator: volume times temperature difference.
    assign w_tdiff = {r_base[SAMPLE_W-1], r_base} - {r_itemp[SAMPLE_W-1], r_itemp};
    assign w_prod  = $signed({1'b0, r_vol}) * w_tdiff;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) r_num <= w_prod[NUM_W-1:0];
    end

    // Flow sign fix-up after the magnitude division.
    assign w_fq       = r_quo[FLOW_W-1:0];
    assign w_flow_neg = r_num[NUM_W-1] ^ r_area[AREA_W-1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept)        r_flow <= '0;
        else if (i_cmd.flow_set) r_flow <= w_flow_neg ? -$signed(w_fq) : $signed(w_fq);
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_filt <= r_last_filt;
            r_o_area <= r_area;
            r_o_flow <= r_flow;
            r_o_sat  <= r_sat;
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.div_done  = (r_cnt == '0);
    assign o_sts.area_zero = (r_area == '0);

    assign o_filtered_temp   = r_o_filt;
    assign o_area            = r_o_area;
    assign o_flow            = r_o_flow;
    assign o_accum_saturated = r_o_sat;

endmodule

>>> hw/rtl/thermodilution_flow_integrator.sv
// Top level of the thermodilution flow integrator.
// Each input word carries an op and a temperature sample. Ops 0 to 2 pass the
// sample through a 32-point boxcar average (ring memory plus running sum) and,
// for op 1, capture the baseline and clear the accumulator, or, for op 2, add
// baseline minus filtered value to a 48-bit saturating accumulator. Op 3 takes
// no sample: it divides the accumulator by 400 into the area register and then
// divides volume times (baseline minus injectate temperature) by the area.
// A sample word passes from acceptance through the decode, filter and apply
// states before its result is loaded into the output register, and the next
// sample is accepted only after that load. A finish word runs the division
// by 400, which produces one quotient byte a cycle (6 steps), and the flow
// division by the area runs one bit a cycle (33 steps). When the area is zero
// the flow division is skipped. One word is processed at a time; the next
// word is accepted while the previous result waits in the output register.
// Configuration writes are taken at any cycle.
module thermodilution_flow_integrator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [tfi_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [tfi_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [tfi_pkg::OP_W-1:0]              i_op,
    input  logic signed [tfi_pkg::SAMPLE_W-1:0]   i_temp_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [tfi_pkg::SAMPLE_W-1:0]   o_filtered_temp,
    output logic signed [tfi_pkg::AREA_W-1:0]     o_area,
    output logic signed [tfi_pkg::FLOW_W-1:0]     o_flow,
    output logic                                  o_accum_saturated
);
    import tfi_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Controller.
    tfi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Datapath.
    tfi_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_op              (i_op),
        .i_temp_sample     (i_temp_sample),
        .o_filtered_temp   (o_filtered_temp),
        .o_area            (o_area),
        .o_flow            (o_flow),
        .o_accum_saturated (o_accum_saturated)
    );

endmodule
